// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lupp_pkg.sv =====
// Package of the LU solver: sizes, action and status codes, Q-format helpers.
// No dependencies; imported by the interfaces, the divider, the top level and the checker.
package lupp_pkg;
	localparam int N_MAX     = 16;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W     = $clog2(N_MAX);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SIZE_W    = 5;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	localparam logic [ACT_W-1:0] ACT_WR_MAT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FACTOR = 3'd1;
	localparam logic [ACT_W-1:0] ACT_WR_RHS = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SOLVE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SINGULAR = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FACT = 2'd2;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Floor shift of a full product, then saturate.
	function automatic logic signed [DATA_W-1:0] sat_mul(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p >>> FRAC_BITS;
		if (s[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){s[PROD_W-1]}})
			return s[PROD_W-1] ? Q_MIN : Q_MAX;
		return s[DATA_W-1:0];
	endfunction

	// Exact difference, then saturate.
	function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1])
			return d[DATA_W] ? Q_MIN : Q_MAX;
		return d[DATA_W-1:0];
	endfunction
endpackage

// ===== sv/lupp_if.sv =====
// Channel interfaces of the LU solver: request, response and size write.
// Depends on lupp_pkg.
interface lupp_req_if import lupp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DATA_W-1:0] entry_value;
	modport source(output valid, action, row_index, col_index, entry_value, input ready);
	modport sink(input valid, action, row_index, col_index, entry_value, output ready);
endinterface

interface lupp_rsp_if import lupp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] result_value;
	logic [IDX_W-1:0]         result_index;
	logic [IDX_W-1:0]         perm_row;
	logic                     last;
	modport source(output valid, status, result_value, result_index, perm_row, last,
		input ready);
	modport sink(input valid, status, result_value, result_index, perm_row, last,
		output ready);
endinterface

interface lupp_cfg_if import lupp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] matrix_size;
	modport source(output valid, matrix_size, input ready);
	modport sink(input valid, matrix_size, output ready);
endinterface

// ===== sv/lupp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lupp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/lupp_div.sv =====
// Bit-serial saturating Q-format divider, one quotient bit per cycle.
// Depends on lupp_pkg.
module lupp_div import lupp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient
);
	localparam int DVD_W = DATA_W + FRAC_BITS;
	localparam int DCW   = $clog2(DVD_W + 1);

	logic              busy_q, fin_q, zero_q, neg_q;
	logic [DCW-1:0]    cnt_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic signed [DATA_W-1:0] zres_q;
	logic [DATA_W-1:0] mag_a, mag_b;
	logic [DATA_W:0]   trial;
	logic              fit;

	assign mag_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q[DATA_W-1:0], dvd_q[DVD_W-1]};
	assign fit   = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				if (divisor == '0) begin
					fin_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DCW'(DVD_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (divisor == '0);
			zres_q <= (dividend == '0) ? '0 : (dividend[DATA_W-1] ? Q_MIN : Q_MAX);
			neg_q  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			dsr_q  <= mag_b;
			dvd_q  <= {mag_a, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? (trial - {1'b0, dsr_q}) : trial;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fit};
		end
	end

	assign done = fin_q;

	always_comb begin
		if (zero_q)
			quotient = zres_q;
		else if (neg_q)
			quotient = (quo_q > DVD_W'({1'b1, {(DATA_W-1){1'b0}}})) ? Q_MIN
				: DATA_W'(~quo_q[DATA_W-1:0] + 1'b1);
		else
			quotient = (quo_q > DVD_W'(Q_MAX)) ? Q_MAX : quo_q[DATA_W-1:0];
	end
endmodule

// ===== sv/lu_partial_pivot_solver_unit.sv =====
// LU solver with partial pivoting, top level.
// Depends on lupp_pkg, the channel interfaces, lupp_ram and lupp_div.
//
// Load a square matrix (order set by matrix_size, clamped to 1..16) and the
// right-hand side one entry per request; loads are taken every cycle while
// the unit is idle. A factor request factors the matrix in place in Q16.16
// with row pivoting on the largest magnitude and answers ok or singular. A
// solve request emits the whole solution vector, element by element, the
// last one marked; a read request returns one LU entry with the permutation
// entry of its row. Solve and read before a good factor answer "not
// factored". The request side is not ready while a factor, solve or read is
// at work. All matrix traffic goes through one RAM with one write port and
// one read port (read data registered), every product goes through one
// 32x32 multiplier and every quotient through one divider that makes one
// bit per cycle. Each result waits in the output register until taken.
module lu_partial_pivot_solver_unit import lupp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lupp_cfg_if.sink  cfg,
	lupp_req_if.sink  req,
	lupp_rsp_if.source rsp
);
	typedef enum logic [27:0] {
		ST_IDLE   = 28'h0000001,
		ST_F_INIT = 28'h0000002,
		ST_P_RD   = 28'h0000004,
		ST_P_CMP  = 28'h0000008,
		ST_P_CHK  = 28'h0000010,
		ST_W_RA   = 28'h0000020,
		ST_W_RB   = 28'h0000040,
		ST_W_WA   = 28'h0000080,
		ST_W_WB   = 28'h0000100,
		ST_W_PA   = 28'h0000200,
		ST_W_PB   = 28'h0000400,
		ST_E_RD   = 28'h0000800,
		ST_E_DST  = 28'h0001000,
		ST_E_DIV  = 28'h0002000,
		ST_J_RK   = 28'h0004000,
		ST_J_MUL  = 28'h0008000,
		ST_J_WR   = 28'h0010000,
		ST_F_OUT  = 28'h0020000,
		ST_S_GATH = 28'h0040000,
		ST_M_RD   = 28'h0080000,
		ST_M_MUL  = 28'h0100000,
		ST_M_SUB  = 28'h0200000,
		ST_B_RDD  = 28'h0400000,
		ST_B_DST  = 28'h0800000,
		ST_B_DIV  = 28'h1000000,
		ST_S_OUT  = 28'h2000000,
		ST_R_OUT  = 28'h4000000,
		ST_NF_OUT = 28'h8000000
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n_q, k_q, i_q, j_q;
	logic [IDX_W-1:0]  best_q, row_q, ptmp_q;
	logic              first_q, bwd_q, factored_q;

	// Datapath registers
	logic [DATA_W-1:0]        bestmag_q;
	logic signed [DATA_W-1:0] piv_q, tmp_q, l_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [STAT_W-1:0]        fstat_q;
	logic [IDX_W-1:0]         perm_q [N_MAX];
	logic signed [DATA_W-1:0] rhs_q  [N_MAX];
	logic signed [DATA_W-1:0] work_q [N_MAX];

	// Output register
	logic                     rsp_valid_q;
	logic [STAT_W-1:0]        rsp_status_q;
	logic signed [DATA_W-1:0] rsp_value_q;
	logic [IDX_W-1:0]         rsp_index_q, rsp_perm_q;
	logic                     rsp_last_q;

	logic                     acc, out_free, emit, take;
	logic [CNT_W-1:0]         order_n;
	logic                     ram_we, ram_re;
	logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
	logic signed [DATA_W-1:0] ram_wdata, ram_rdata;
	logic [IDX_W-1:0]         psel, wsel, perm_rd;
	logic signed [DATA_W-1:0] work_rd, rhs_rd, mul_a, sub_x, sub_res;
	logic signed [PROD_W-1:0] mul_full;
	logic [DATA_W-1:0]        mag_rd;
	logic                     div_start, div_done;
	logic signed [DATA_W-1:0] div_a, div_b, div_q;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign emit      = out_free && (state_q == ST_F_OUT || state_q == ST_S_OUT
		|| state_q == ST_R_OUT || state_q == ST_NF_OUT);

	// Clamp the configured order to 1..N_MAX
	always_comb begin
		if (size_q == '0)
			order_n = CNT_W'(1);
		else if (CNT_W'(size_q) > CNT_W'(N_MAX))
			order_n = CNT_W'(N_MAX);
		else
			order_n = CNT_W'(size_q);
	end

	// Small-store read selects: one address each
	always_comb begin
		psel = k_q[IDX_W-1:0];
		if (state_q == ST_W_PB) psel = best_q;
		else if (state_q == ST_R_OUT) psel = row_q;
		else if (state_q == ST_S_GATH || state_q == ST_S_OUT) psel = i_q[IDX_W-1:0];
		wsel = (state_q == ST_M_MUL) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	end
	assign perm_rd = perm_q[psel];
	assign work_rd = work_q[wsel];
	assign rhs_rd  = rhs_q[perm_rd];

	// Shared multiplier, saturating subtract and magnitude
	assign mul_a    = (state_q == ST_J_MUL) ? l_q : work_rd;
	assign mul_full = PROD_W'(mul_a) * PROD_W'(ram_rdata);
	assign sub_x    = (state_q == ST_J_WR) ? ram_rdata : work_rd;
	assign sub_res  = sat_sub(sub_x, sat_mul(prod_q));
	assign mag_rd   = ram_rdata[DATA_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
	assign take     = first_q || (mag_rd > bestmag_q);

	// Shared divider: pivot quotient in the factor, diagonal in the solve
	assign div_start = (state_q == ST_E_DST) || (state_q == ST_B_DST);
	assign div_a     = (state_q == ST_E_DST) ? ram_rdata : work_rd;
	assign div_b     = (state_q == ST_E_DST) ? piv_q : ram_rdata;

	lupp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// Matrix RAM port steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
		ram_we    = 1'b0;
		ram_waddr = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
		ram_wdata = sub_res;
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = acc && (req.action == ACT_READ);
				ram_raddr = {req.row_index, req.col_index};
				ram_we    = acc && (req.action == ACT_WR_MAT);
				ram_waddr = {req.row_index, req.col_index};
				ram_wdata = req.entry_value;
			end
			ST_P_RD, ST_E_RD: ram_re = 1'b1;
			ST_W_RA, ST_J_RK: begin
				ram_re    = 1'b1;
				ram_raddr = {k_q[IDX_W-1:0], j_q[IDX_W-1:0]};
			end
			ST_W_RB: begin
				ram_re    = 1'b1;
				ram_raddr = {best_q, j_q[IDX_W-1:0]};
			end
			ST_J_MUL, ST_M_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
			end
			ST_B_RDD: begin
				ram_re    = 1'b1;
				ram_raddr = {i_q[IDX_W-1:0], i_q[IDX_W-1:0]};
			end
			ST_W_WA: begin
				ram_we    = 1'b1;
				ram_waddr = {k_q[IDX_W-1:0], j_q[IDX_W-1:0]};
				ram_wdata = ram_rdata;
			end
			ST_W_WB: begin
				ram_we    = 1'b1;
				ram_waddr = {best_q, j_q[IDX_W-1:0]};
				ram_wdata = tmp_q;
			end
			ST_E_DIV: begin
				ram_we    = div_done;
				ram_waddr = {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
				ram_wdata = div_q;
			end
			ST_J_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	lupp_ram #(.WIDTH(DATA_W), .DEPTH(1 << ADDR_W)) u_mat (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SIZE_W'(N_MAX);
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			best_q      <= '0;
			first_q     <= 1'b0;
			bwd_q       <= 1'b0;
			factored_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) size_q <= cfg.matrix_size;

			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.action)
							ACT_WR_MAT: factored_q <= 1'b0;
							ACT_FACTOR: begin
								n_q     <= order_n;
								state_q <= ST_F_INIT;
							end
							ACT_SOLVE: begin
								n_q     <= order_n;
								i_q     <= '0;
								state_q <= factored_q ? ST_S_GATH : ST_NF_OUT;
							end
							ACT_READ: state_q <= factored_q ? ST_R_OUT : ST_NF_OUT;
							default: ;
						endcase
					end
				end
				ST_F_INIT: begin
					k_q     <= '0;
					i_q     <= '0;
					first_q <= 1'b1;
					state_q <= ST_P_RD;
				end
				ST_P_RD: state_q <= ST_P_CMP;
				ST_P_CMP: begin
					first_q <= 1'b0;
					if (take) best_q <= i_q[IDX_W-1:0];
					if (i_q + 1'b1 < n_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_P_RD;
					end else begin
						state_q <= ST_P_CHK;
					end
				end
				ST_P_CHK: begin
					if (piv_q == '0) begin
						factored_q <= 1'b0;
						state_q    <= ST_F_OUT;
					end else if (best_q != k_q[IDX_W-1:0]) begin
						j_q     <= '0;
						state_q <= ST_W_RA;
					end else if (k_q + 1'b1 < n_q) begin
						i_q     <= k_q + 1'b1;
						state_q <= ST_E_RD;
					end else begin
						factored_q <= 1'b1;
						state_q    <= ST_F_OUT;
					end
				end
				ST_W_RA: state_q <= ST_W_RB;
				ST_W_RB: state_q <= ST_W_WA;
				ST_W_WA: state_q <= ST_W_WB;
				ST_W_WB: begin
					if (j_q + 1'b1 < n_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_W_RA;
					end else begin
						state_q <= ST_W_PA;
					end
				end
				ST_W_PA: state_q <= ST_W_PB;
				ST_W_PB: begin
					if (k_q + 1'b1 < n_q) begin
						i_q     <= k_q + 1'b1;
						state_q <= ST_E_RD;
					end else begin
						factored_q <= 1'b1;
						state_q    <= ST_F_OUT;
					end
				end
				ST_E_RD:  state_q <= ST_E_DST;
				ST_E_DST: state_q <= ST_E_DIV;
				ST_E_DIV: begin
					if (div_done) begin
						j_q     <= k_q + 1'b1;
						state_q <= ST_J_RK;
					end
				end
				ST_J_RK:  state_q <= ST_J_MUL;
				ST_J_MUL: state_q <= ST_J_WR;
				ST_J_WR: begin
					if (j_q + 1'b1 < n_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_J_RK;
					end else if (i_q + 1'b1 < n_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_E_RD;
					end else if (k_q + 1'b1 < n_q) begin
						// advance to the next column
						k_q     <= k_q + 1'b1;
						i_q     <= k_q + 1'b1;
						first_q <= 1'b1;
						state_q <= ST_P_RD;
					end else begin
						factored_q <= 1'b1;
						state_q    <= ST_F_OUT;
					end
				end
				ST_F_OUT, ST_R_OUT, ST_NF_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_S_GATH: begin
					if (i_q + 1'b1 < n_q) begin
						i_q <= i_q + 1'b1;
					end else if (n_q > CNT_W'(1)) begin
						i_q     <= CNT_W'(1);
						j_q     <= '0;
						bwd_q   <= 1'b0;
						state_q <= ST_M_RD;
					end else begin
						i_q     <= n_q - 1'b1;
						state_q <= ST_B_RDD;
					end
				end
				ST_M_RD:  state_q <= ST_M_MUL;
				ST_M_MUL: state_q <= ST_M_SUB;
				ST_M_SUB: begin
					if (!bwd_q) begin
						if (j_q + 1'b1 < i_q) begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_M_RD;
						end else if (i_q + 1'b1 < n_q) begin
							i_q     <= i_q + 1'b1;
							j_q     <= '0;
							state_q <= ST_M_RD;
						end else begin
							i_q     <= n_q - 1'b1;
							state_q <= ST_B_RDD;
						end
					end else if (j_q + 1'b1 < n_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_M_RD;
					end else begin
						state_q <= ST_B_RDD;
					end
				end
				ST_B_RDD: state_q <= ST_B_DST;
				ST_B_DST: state_q <= ST_B_DIV;
				ST_B_DIV: begin
					if (div_done) begin
						if (i_q == '0) begin
							state_q <= ST_S_OUT;
						end else begin
							// step up one row; its tail starts at the row just solved
							i_q     <= i_q - 1'b1;
							j_q     <= i_q;
							bwd_q   <= 1'b1;
							state_q <= ST_M_RD;
						end
					end
				end
				ST_S_OUT: begin
					if (out_free) begin
						if (i_q + 1'b1 == n_q) state_q <= ST_IDLE;
						else i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath and small stores
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.action == ACT_WR_RHS) rhs_q[req.row_index] <= req.entry_value;
				if (acc && req.action == ACT_READ) row_q <= req.row_index;
			end
			ST_F_INIT: begin
				for (int e = 0; e < N_MAX; e++)
					if (CNT_W'(e) < n_q) perm_q[e] <= IDX_W'(e);
			end
			ST_P_CMP: begin
				if (take) begin
					bestmag_q <= mag_rd;
					piv_q     <= ram_rdata;
				end
			end
			ST_P_CHK: fstat_q <= (piv_q == '0) ? STAT_SINGULAR : STAT_OK;
			ST_W_RB:  tmp_q <= ram_rdata;
			ST_W_PA:  ptmp_q <= perm_rd;
			ST_W_PB: begin
				perm_q[k_q[IDX_W-1:0]] <= perm_rd;
				perm_q[best_q]         <= ptmp_q;
			end
			ST_E_DIV: if (div_done) l_q <= div_q;
			ST_J_MUL, ST_M_MUL: prod_q <= mul_full;
			ST_S_GATH: work_q[i_q[IDX_W-1:0]] <= rhs_rd;
			ST_M_SUB:  work_q[i_q[IDX_W-1:0]] <= sub_res;
			ST_B_DIV:  if (div_done) work_q[i_q[IDX_W-1:0]] <= div_q;
			default: ;
		endcase

		// Load the output register on a result
		if (emit) begin
			rsp_status_q <= STAT_OK;
			rsp_value_q  <= '0;
			rsp_index_q  <= '0;
			rsp_perm_q   <= '0;
			rsp_last_q   <= 1'b1;
			case (state_q)
				ST_F_OUT:  rsp_status_q <= fstat_q;
				ST_NF_OUT: rsp_status_q <= STAT_NOT_FACT;
				ST_R_OUT: begin
					rsp_value_q <= ram_rdata;
					rsp_index_q <= row_q;
					rsp_perm_q  <= perm_rd;
				end
				ST_S_OUT: begin
					rsp_value_q <= work_rd;
					rsp_index_q <= i_q[IDX_W-1:0];
					rsp_perm_q  <= perm_rd;
					rsp_last_q  <= (i_q + 1'b1 == n_q);
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.result_index = rsp_index_q;
	assign rsp.perm_row     = rsp_perm_q;
	assign rsp.last         = rsp_last_q;
endmodule

// ===== sv/lupp_checker.sv =====
// Port-level checker for the LU solver, bound to the top level.
// Depends on lupp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lupp_port_checker import lupp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic [ACT_W-1:0]         req_action,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [STAT_W-1:0]        rsp_status,
	input logic signed [DATA_W-1:0] rsp_value,
	input logic [IDX_W-1:0]         rsp_index,
	input logic                     rsp_last
);
	logic err_rsp;

	assign err_rsp = rsp_valid && rsp_status != STAT_OK;

	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped before taken")
	`CHK_SAME(a_stat_code, rsp_valid, rsp_status <= STAT_NOT_FACT, "undefined status code")
	`CHK_SAME(a_err_last, err_rsp, rsp_last, "error not marked last")
	`CHK_SAME(a_err_zero, err_rsp, rsp_value == '0 && rsp_index == '0, "error carries payload")
	`CHK_NEXT(a_factor_busy, req_valid && req_ready && req_action == ACT_FACTOR, !req_ready, "ready during factor")
endmodule

bind lu_partial_pivot_solver_unit lupp_port_checker u_lupp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_value  (rsp.result_value),
	.rsp_index  (rsp.result_index),
	.rsp_last   (rsp.last)
);
